// File: design/vgu_pkg.sv
// Shared constants, operation codes and channel payload types of the vector geometry unit.
// No dependencies; every other file of the block imports this package.
package vgu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_W = 32;

   localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS;
   localparam longint EPS_Q = ONE_Q / 10000;
   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;
   localparam logic [63:0] ONE2_Q = 64'd1 << (2 * FRAC_BITS);

   // Square root: two result bits per stage over a 64-bit radicand.
   localparam int SQRT_STEPS = 2;
   localparam int SQRT_STAGES = 32 / SQRT_STEPS;

   // Division: the quotient has one bit for every bit of |a| << FRAC_BITS.
   localparam int DIV_W = WORD_W + FRAC_BITS;
   localparam int DIV_STEPS = 3;
   localparam int DIV_STAGES = (DIV_W + DIV_STEPS - 1) / DIV_STEPS;

   localparam logic [3:0] OP_ADD      = 4'd0;
   localparam logic [3:0] OP_SUB      = 4'd1;
   localparam logic [3:0] OP_MUL      = 4'd2;
   localparam logic [3:0] OP_SCALE    = 4'd3;
   localparam logic [3:0] OP_DIV      = 4'd4;
   localparam logic [3:0] OP_SDIV     = 4'd5;
   localparam logic [3:0] OP_NEG      = 4'd6;
   localparam logic [3:0] OP_DOT      = 4'd7;
   localparam logic [3:0] OP_CROSS    = 4'd8;
   localparam logic [3:0] OP_LEN      = 4'd9;
   localparam logic [3:0] OP_LENSQ    = 4'd10;
   localparam logic [3:0] OP_NORM     = 4'd11;
   localparam logic [3:0] OP_NEARZERO = 4'd12;
   localparam logic [3:0] OP_REFLECT  = 4'd13;
   localparam logic [3:0] OP_REFRACT  = 4'd14;

   typedef logic signed [31:0] word_type;
   typedef logic signed [63:0] wide_type;

   typedef struct packed {
      logic [3:0] func;
      word_type   a_x;
      word_type   a_y;
      word_type   a_z;
      word_type   b_x;
      word_type   b_y;
      word_type   b_z;
      word_type   scalar_in;
   } req_payload_type;

   typedef struct packed {
      word_type r_x;
      word_type r_y;
      word_type r_z;
      word_type scalar_out;
      logic     is_near_zero;
      logic     saturated;
   } rsp_payload_type;

endpackage

// File: design/vgu_req_if.sv
// Request channel of the vector geometry unit: valid, ready and one operation item.
// Depends on vgu_pkg for the payload type.
interface vgu_req_if import vgu_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: design/vgu_rsp_if.sv
// Response channel of the vector geometry unit: valid, ready and one result item.
// Depends on vgu_pkg for the payload type.
interface vgu_rsp_if import vgu_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: design/vector3_geometry_unit_core.sv
// Vector geometry unit: a fully pipelined 3D vector unit in signed Q16.16 fixed point.
// Depends on vgu_pkg, vgu_req_if and vgu_rsp_if.
//
// Usage: each request item on req_ch carries an operation code, vectors a and b and a
// scalar; each one produces exactly one result item on rsp_ch, in the same order.
// Both channels transfer an item on a rising clock edge with valid and ready high.
// The item passes 44 register stages: nine front stages (request capture, products,
// sums, the reflect and refract chain), sixteen square-root stages that retire two root
// bits each, one divider setup stage, sixteen restoring-division stages that retire three
// quotient bits each, a combine stage and the output register. The first stage loads at
// the accepting edge, and rsp_ch.valid rises once the item reaches the output register.
// Throughput is one item per cycle while rsp_ch.ready stays high; every stage holds one
// item and moves it on whenever the stage after it is empty or moving, so bubbles close
// up and a new item is taken while a finished result waits for the receiver.
// When the receiver holds rsp_ch.ready low the result stays in the output register and
// the stages behind it fill up; req_ch.ready drops only once every stage is occupied.
// Reset is synchronous and clears the valid bits of all stages; stage data is not reset.
module vector3_geometry_unit_core import vgu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   vgu_req_if.sink   req_ch,
   vgu_rsp_if.source rsp_ch
);

   localparam int ST_IN   = 0;
   localparam int ST_MUL  = 1;
   localparam int ST_SUM  = 2;
   localparam int ST_KMUL = 3;
   localparam int ST_RFX  = 4;
   localparam int ST_PMUL = 5;
   localparam int ST_PSAT = 6;
   localparam int ST_PSQ  = 7;
   localparam int ST_RAD  = 8;
   localparam int ST_SQ0  = 9;
   localparam int ST_DSET = ST_SQ0 + SQRT_STAGES;
   localparam int ST_DV0  = ST_DSET + 1;
   localparam int ST_FIN  = ST_DV0 + DIV_STAGES;
   localparam int ST_OUT  = ST_FIN + 1;
   localparam int NSTG    = ST_OUT + 1;

   // One item in flight. The working vectors w, x and y are reused from stage to stage:
   // w ends up as the result vector, x and y hold products and intermediate vectors.
   typedef struct packed {
      logic [3:0]                  op;
      logic                        nz;
      logic                        flag;
      word_type [2:0]              a;
      word_type [2:0]              b;
      word_type                    sc;
      word_type                    k;
      wide_type [2:0]              w;
      wide_type [2:0]              x;
      wide_type [2:0]              y;
      wide_type                    so;
      logic [63:0]                 u;
      logic [35:0]                 srem;
      logic [31:0]                 root;
      logic [2:0][DIV_W-1:0]       dnum;
      logic [2:0][32:0]            drem;
      logic [31:0]                 dm;
      logic [2:0]                  dneg;
      logic                        dact;
   } pipe_type;

   pipe_type        st_ff [NSTG];
   pipe_type        st_in [NSTG];
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] v_in;
   logic [NSTG-1:0] en;

   function automatic wide_type sx(input word_type v);
      return wide_type'(v);
   endfunction

   function automatic wide_type flr(input wide_type v);
      return v >>> FRAC_BITS;
   endfunction

   function automatic wide_type mul32(input word_type x, input word_type y);
      return sx(x) * sx(y);
   endfunction

   function automatic logic sat_hit(input wide_type v);
      return (v > MAX32) || (v < MIN32);
   endfunction

   function automatic word_type sat_val(input wide_type v);
      if (v > MAX32) begin
         return 32'sh7fffffff;
      end else if (v < MIN32) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic [31:0] mag32(input word_type v);
      wide_type n;
      n = -sx(v);
      return v[31] ? n[31:0] : v;
   endfunction

   // Handshake: a stage loads when it is empty or its item moves on.
   always_comb begin
      en[NSTG-1] = ~v_ff[NSTG-1] | rsp_ch.ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = ~v_ff[k] | en[k+1];
      end
      v_in[0] = req_ch.valid;
      for (int k = 1; k < NSTG; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   assign req_ch.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTG; k++) begin
         if (en[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // Capture the request and flag an all-zero vector a.
   always_comb begin
      pipe_type p;
      p = '0;
      p.op = req_ch.data.func;
      p.a[0] = req_ch.data.a_x;
      p.a[1] = req_ch.data.a_y;
      p.a[2] = req_ch.data.a_z;
      p.b[0] = req_ch.data.b_x;
      p.b[1] = req_ch.data.b_y;
      p.b[2] = req_ch.data.b_z;
      p.sc = req_ch.data.scalar_in;
      p.nz = (req_ch.data.a_x == 0) && (req_ch.data.a_y == 0) && (req_ch.data.a_z == 0);
      st_in[ST_IN] = p;
   end

   // Products: w holds a*b, a*scalar or a*a; x and y hold the two halves of the cross.
   always_comb begin
      pipe_type p;
      word_type op2;
      p = st_ff[ST_IN];
      for (int i = 0; i < 3; i++) begin
         if (p.op == OP_SCALE) begin
            op2 = p.sc;
         end else if ((p.op == OP_LEN) || (p.op == OP_LENSQ) || (p.op == OP_NORM)) begin
            op2 = p.a[i];
         end else begin
            op2 = p.b[i];
         end
         p.w[i] = mul32(p.a[i], op2);
      end
      p.x[0] = mul32(p.a[1], p.b[2]);
      p.x[1] = mul32(p.a[2], p.b[0]);
      p.x[2] = mul32(p.a[0], p.b[1]);
      p.y[0] = mul32(p.a[2], p.b[1]);
      p.y[1] = mul32(p.a[0], p.b[2]);
      p.y[2] = mul32(p.a[1], p.b[0]);
      st_in[ST_MUL] = p;
   end

   // Sums: the simple vector results, the dot product, the sum of squares, and the
   // factor that the reflect and refract chain multiplies b by.
   always_comb begin
      pipe_type    p;
      wide_type    fw [3];
      wide_type    cr [3];
      wide_type    dsum;
      word_type    d;
      logic        dsat;
      logic [63:0] ssq;
      wide_type    negd;
      p = st_ff[ST_MUL];
      for (int i = 0; i < 3; i++) begin
         fw[i] = flr(p.w[i]);
         cr[i] = flr(p.x[i]) - flr(p.y[i]);
      end
      dsum = fw[0] + fw[1] + fw[2];
      d = sat_val(dsum);
      dsat = sat_hit(dsum);
      ssq = p.w[0] + p.w[1] + p.w[2];
      negd = -sx(d);
      p.w = '0;
      p.so = '0;
      p.k = '0;
      p.u = '0;
      case (p.op)
         OP_ADD: begin
            for (int i = 0; i < 3; i++) p.w[i] = sx(p.a[i]) + sx(p.b[i]);
         end
         OP_SUB: begin
            for (int i = 0; i < 3; i++) p.w[i] = sx(p.a[i]) - sx(p.b[i]);
         end
         OP_MUL, OP_SCALE: begin
            for (int i = 0; i < 3; i++) p.w[i] = fw[i];
         end
         OP_NEG: begin
            for (int i = 0; i < 3; i++) p.w[i] = -sx(p.a[i]);
         end
         OP_DOT: begin
            p.so = sx(d);
            p.flag = p.flag | dsat;
         end
         OP_CROSS: begin
            for (int i = 0; i < 3; i++) p.w[i] = cr[i];
         end
         OP_LEN, OP_NORM: begin
            p.u = ssq;
         end
         OP_LENSQ: begin
            p.so = $signed({{FRAC_BITS{1'b0}}, ssq[63:FRAC_BITS]});
         end
         OP_REFLECT: begin
            p.k = d;
            p.flag = p.flag | dsat;
         end
         OP_REFRACT: begin
            p.k = (negd > ONE_Q) ? 32'(ONE_Q) : negd[31:0];
            p.flag = p.flag | dsat;
         end
         default: begin
         end
      endcase
      st_in[ST_SUM] = p;
   end

   always_comb begin
      pipe_type p;
      p = st_ff[ST_SUM];
      for (int i = 0; i < 3; i++) p.x[i] = mul32(p.k, p.b[i]);
      st_in[ST_KMUL] = p;
   end

   // Reflect finishes its vector here; refract forms the clamped inner vector.
   always_comb begin
      pipe_type p;
      wide_type fm;
      wide_type s;
      p = st_ff[ST_KMUL];
      for (int i = 0; i < 3; i++) begin
         fm = flr(p.x[i]);
         s = sx(p.a[i]) + fm;
         if (p.op == OP_REFLECT) begin
            p.w[i] = sx(p.a[i]) - (fm + fm);
         end
         if (p.op == OP_REFRACT) begin
            p.y[i] = sx(sat_val(s));
            p.flag = p.flag | sat_hit(s);
         end
      end
      st_in[ST_RFX] = p;
   end

   always_comb begin
      pipe_type p;
      p = st_ff[ST_RFX];
      for (int i = 0; i < 3; i++) p.x[i] = mul32(p.sc, p.y[i][31:0]);
      st_in[ST_PMUL] = p;
   end

   always_comb begin
      pipe_type p;
      wide_type s;
      p = st_ff[ST_PMUL];
      for (int i = 0; i < 3; i++) begin
         s = flr(p.x[i]);
         if (p.op == OP_REFRACT) begin
            p.y[i] = sx(sat_val(s));
            p.flag = p.flag | sat_hit(s);
         end
      end
      st_in[ST_PSAT] = p;
   end

   always_comb begin
      pipe_type p;
      p = st_ff[ST_PSAT];
      for (int i = 0; i < 3; i++) p.x[i] = mul32(p.y[i][31:0], p.y[i][31:0]);
      st_in[ST_PSQ] = p;
   end

   // Refract radicand: distance of |p|^2 from one, taken as a magnitude.
   always_comb begin
      pipe_type    p;
      logic [63:0] s;
      p = st_ff[ST_PSQ];
      s = p.x[0] + p.x[1] + p.x[2];
      if (p.op == OP_REFRACT) begin
         p.u = (s >= ONE2_Q) ? (s - ONE2_Q) : (ONE2_Q - s);
      end
      p.srem = '0;
      p.root = '0;
      st_in[ST_RAD] = p;
   end

   // Digit-by-digit square root, two radicand bits per step.
   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
      always_comb begin
         pipe_type    p;
         logic [35:0] rem;
         logic [35:0] trial;
         p = st_ff[ST_SQ0 + s - 1];
         for (int j = 0; j < SQRT_STEPS; j++) begin
            rem = {p.srem[33:0], p.u[63:62]};
            p.u = {p.u[61:0], 2'b00};
            trial = {2'b00, p.root, 2'b01};
            if (rem >= trial) begin
               p.srem = rem - trial;
               p.root = {p.root[30:0], 1'b1};
            end else begin
               p.srem = rem;
               p.root = {p.root[30:0], 1'b0};
            end
         end
         st_in[ST_SQ0 + s] = p;
      end
   end

   // Uses of the root, and divider setup for divide, guarded divide and normalize.
   always_comb begin
      pipe_type    p;
      wide_type    rootw;
      logic [31:0] dmag;
      logic        dsign;
      p = st_ff[ST_DSET - 1];
      rootw = $signed({32'b0, p.root});
      if (p.op == OP_LEN) begin
         p.so = rootw;
      end
      for (int i = 0; i < 3; i++) p.x[i] = rootw * sx(p.b[i]);
      if (p.op == OP_NORM) begin
         dmag = p.root;
         dsign = 1'b0;
         p.dact = rootw > EPS_Q;
      end else begin
         dmag = mag32(p.sc);
         dsign = p.sc[31];
         p.dact = ((p.op == OP_DIV) && (p.sc != 0)) ||
                  ((p.op == OP_SDIV) && (sx(p.sc) > EPS_Q));
      end
      p.dm = dmag;
      for (int i = 0; i < 3; i++) begin
         p.dnum[i] = {mag32(p.a[i]), {FRAC_BITS{1'b0}}};
         p.drem[i] = '0;
         p.dneg[i] = p.a[i][31] ^ dsign;
         if ((p.op == OP_DIV) && (p.sc == 0)) begin
            if (sx(p.a[i]) > 0) begin
               p.w[i] = MAX32;
            end else if (sx(p.a[i]) < 0) begin
               p.w[i] = MIN32;
            end else begin
               p.w[i] = '0;
            end
            p.flag = 1'b1;
         end
         if ((p.op == OP_SDIV) && !p.dact) begin
            p.w[i] = sx(p.a[i]);
         end
      end
      st_in[ST_DSET] = p;
   end

   // Restoring division on magnitudes; quotient bits shift into the dividend register.
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      always_comb begin
         pipe_type    p;
         logic [32:0] rem;
         p = st_ff[ST_DV0 + s - 1];
         for (int j = 0; j < DIV_STEPS; j++) begin
            if (s * DIV_STEPS + j < DIV_W) begin
               for (int i = 0; i < 3; i++) begin
                  rem = {p.drem[i][31:0], p.dnum[i][DIV_W-1]};
                  p.dnum[i] = {p.dnum[i][DIV_W-2:0], 1'b0};
                  if (rem >= {1'b0, p.dm}) begin
                     rem = rem - {1'b0, p.dm};
                     p.dnum[i][0] = 1'b1;
                  end
                  p.drem[i] = rem;
               end
            end
         end
         st_in[ST_DV0 + s] = p;
      end
   end

   // Combine: signed quotients, and the refract vector p - floor(root*b).
   always_comb begin
      pipe_type p;
      wide_type q;
      p = st_ff[ST_FIN - 1];
      for (int i = 0; i < 3; i++) begin
         q = $signed({{(64 - DIV_W){1'b0}}, p.dnum[i]});
         if (p.dact) begin
            p.w[i] = p.dneg[i] ? -q : q;
         end
         if (p.op == OP_REFRACT) begin
            p.w[i] = p.y[i] - flr(p.x[i]);
         end
      end
      st_in[ST_FIN] = p;
   end

   // Output register: clamp every field to 32 bits and note any clamp.
   always_comb begin
      pipe_type p;
      p = st_ff[ST_FIN];
      for (int i = 0; i < 3; i++) begin
         p.flag = p.flag | sat_hit(p.w[i]);
         p.w[i] = sx(sat_val(p.w[i]));
      end
      p.flag = p.flag | sat_hit(p.so);
      p.so = sx(sat_val(p.so));
      st_in[ST_OUT] = p;
   end

   assign rsp_ch.valid = v_ff[ST_OUT];
   assign rsp_ch.data.r_x = st_ff[ST_OUT].w[0][31:0];
   assign rsp_ch.data.r_y = st_ff[ST_OUT].w[1][31:0];
   assign rsp_ch.data.r_z = st_ff[ST_OUT].w[2][31:0];
   assign rsp_ch.data.scalar_out = st_ff[ST_OUT].so[31:0];
   assign rsp_ch.data.is_near_zero = st_ff[ST_OUT].nz;
   assign rsp_ch.data.saturated = st_ff[ST_OUT].flag;

`ifndef SYNTH
   // A held first stage keeps its item intact.
   a_hold_first: assert property (@(posedge clock) disable iff (reset)
      (v_ff[ST_IN] && !en[ST_IN]) |=> (v_ff[ST_IN] && $stable(st_ff[ST_IN])))
      else $error("first stage lost or changed a held item");

   // Scalar-only operations leave the result vector at zero.
   a_scalar_ops_zero_vec: assert property (@(posedge clock) disable iff (reset)
      (v_ff[ST_OUT] && ((st_ff[ST_OUT].op == OP_DOT) || (st_ff[ST_OUT].op == OP_LEN) ||
       (st_ff[ST_OUT].op == OP_LENSQ) || (st_ff[ST_OUT].op == OP_NEARZERO))) |->
      ((rsp_ch.data.r_x == 0) && (rsp_ch.data.r_y == 0) && (rsp_ch.data.r_z == 0)))
      else $error("vector result not zero for a scalar operation");

   // Only dot, length and squared length drive the scalar result.
   a_vec_ops_zero_scalar: assert property (@(posedge clock) disable iff (reset)
      (v_ff[ST_OUT] && (st_ff[ST_OUT].op != OP_DOT) && (st_ff[ST_OUT].op != OP_LEN) &&
       (st_ff[ST_OUT].op != OP_LENSQ)) |-> (rsp_ch.data.scalar_out == 0))
      else $error("scalar result not zero for a vector operation");

   // A normalized vector never needs clamping.
   a_norm_no_sat: assert property (@(posedge clock) disable iff (reset)
      (v_ff[ST_OUT] && (st_ff[ST_OUT].op == OP_NORM)) |-> !rsp_ch.data.saturated)
      else $error("normalize reported saturation");
`endif

endmodule

// File: test/vgu_testbench.sv
// Self-checking testbench of the vector geometry unit: directed and random operation items.
// Depends on vgu_pkg, vgu_req_if, vgu_rsp_if and vector3_geometry_unit_core.
module testbench;
   import vgu_pkg::*;

   // The one code that names no operation; its vector and scalar results must be zero.
   localparam logic [3:0] OP_SPARE = 4'd15;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   vgu_req_if req_ch ();
   vgu_rsp_if rsp_ch ();

   vector3_geometry_unit_core dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   rsp_payload_type expected_results[$];
   int mismatch_count = 0;
   int result_count = 0;
   int item_count = 0;
   int unexpected_count = 0;
   longint cycle_count = 0;
   int op_counts[16];

   // The predictor works on sign-extended 64-bit values, like the block's wide datapath.
   function automatic longint floor_q(longint v);
      return v >>> FRAC_BITS;
   endfunction

   function automatic longint clamp32(longint v, ref bit flag);
      if (v > MAX32) begin
         flag = 1'b1;
         return MAX32;
      end
      if (v < MIN32) begin
         flag = 1'b1;
         return MIN32;
      end
      return v;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bit_q;
      root = 0;
      bit_q = 64'd1 << 62;
      while (bit_q > v) bit_q >>= 2;
      while (bit_q != 0) begin
         if (v >= root + bit_q) begin
            v -= root + bit_q;
            root = (root >> 1) + bit_q;
         end else begin
            root >>= 1;
         end
         bit_q >>= 2;
      end
      return root;
   endfunction

   function automatic longint unsigned square_sum(longint v[3]);
      longint unsigned s;
      s = 0;
      for (int i = 0; i < 3; i++) s += longint'(v[i] * v[i]);
      return s;
   endfunction

   function automatic longint clamped_dot(longint a[3], longint b[3], ref bit flag);
      longint s;
      s = 0;
      for (int i = 0; i < 3; i++) s += floor_q(a[i] * b[i]);
      return clamp32(s, flag);
   endfunction

   function automatic rsp_payload_type vector_result(req_payload_type item);
      rsp_payload_type res;
      longint a[3], b[3], r[3], p[3], sc, so, t, c;
      longint unsigned u;
      bit flag;
      a = '{item.a_x, item.a_y, item.a_z};
      b = '{item.b_x, item.b_y, item.b_z};
      r = '{0, 0, 0};
      sc = item.scalar_in;
      so = 0;
      flag = 1'b0;
      case (item.func)
         OP_ADD: for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
         OP_SUB: for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
         OP_MUL: for (int i = 0; i < 3; i++) r[i] = floor_q(a[i] * b[i]);
         OP_SCALE: for (int i = 0; i < 3; i++) r[i] = floor_q(a[i] * sc);
         OP_DIV: begin
            for (int i = 0; i < 3; i++) begin
               if (sc == 0) begin
                  flag = 1'b1;
                  r[i] = a[i] > 0 ? MAX32 : (a[i] < 0 ? MIN32 : 0);
               end else begin
                  r[i] = (a[i] * ONE_Q) / sc;
               end
            end
         end
         OP_SDIV: for (int i = 0; i < 3; i++) r[i] = (sc > EPS_Q) ? (a[i] * ONE_Q) / sc : a[i];
         OP_NEG: for (int i = 0; i < 3; i++) r[i] = -a[i];
         OP_DOT: so = clamped_dot(a, b, flag);
         OP_CROSS: begin
            r[0] = floor_q(a[1] * b[2]) - floor_q(a[2] * b[1]);
            r[1] = floor_q(a[2] * b[0]) - floor_q(a[0] * b[2]);
            r[2] = floor_q(a[0] * b[1]) - floor_q(a[1] * b[0]);
         end
         OP_LEN: so = longint'(floor_sqrt(square_sum(a)));
         OP_LENSQ: so = longint'(square_sum(a) >> FRAC_BITS);
         OP_NORM: begin
            t = longint'(floor_sqrt(square_sum(a)));
            if (t > EPS_Q) for (int i = 0; i < 3; i++) r[i] = (a[i] * ONE_Q) / t;
         end
         OP_NEARZERO: ;
         OP_REFLECT: begin
            t = clamped_dot(a, b, flag);
            for (int i = 0; i < 3; i++) r[i] = a[i] - 2 * floor_q(t * b[i]);
         end
         OP_REFRACT: begin
            c = -clamped_dot(a, b, flag);
            if (c > ONE_Q) c = ONE_Q;
            for (int i = 0; i < 3; i++) begin
               t = clamp32(a[i] + floor_q(c * b[i]), flag);
               p[i] = clamp32(floor_q(sc * t), flag);
            end
            u = square_sum(p);
            u = (u >= ONE2_Q) ? u - ONE2_Q : ONE2_Q - u;
            t = longint'(floor_sqrt(u));
            for (int i = 0; i < 3; i++) r[i] = p[i] - floor_q(t * b[i]);
         end
         default: ;
      endcase
      res.r_x = word_type'(clamp32(r[0], flag));
      res.r_y = word_type'(clamp32(r[1], flag));
      res.r_z = word_type'(clamp32(r[2], flag));
      res.scalar_out = word_type'(clamp32(so, flag));
      res.is_near_zero = (a[0] == 0 && a[1] == 0 && a[2] == 0);
      res.saturated = flag;
      return res;
   endfunction

   // Sends one item after a random gap and records its prediction on acceptance.
   // Valid stays high after acceptance so that items can follow back to back; it drops
   // at the start of a gap, and the caller drops it after the last item.
   task automatic send_item(req_payload_type item);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= item;
      do @(posedge clock); while (!req_ch.ready);
      expected_results.push_back(vector_result(item));
      op_counts[item.func]++;
      item_count++;
      @(negedge clock);
   endtask

   function automatic word_type random_word();
      case ($urandom_range(0, 7))
         0: return word_type'($urandom_range(0, 4)) - 2;
         1: return 32'sh7fffffff;
         2: return 32'sh80000000;
         3, 4: return word_type'($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic req_payload_type random_item(logic [3:0] func);
      req_payload_type item;
      item.func = func;
      item.a_x = random_word();
      item.a_y = random_word();
      item.a_z = random_word();
      item.b_x = random_word();
      item.b_y = random_word();
      item.b_z = random_word();
      item.scalar_in = random_word();
      if ($urandom_range(0, 5) == 0) item.scalar_in = word_type'($urandom_range(0, 12)) - 3;
      return item;
   endfunction

   function automatic req_payload_type make_item(logic [3:0] func, word_type ax, word_type ay,
                                                 word_type az, word_type bx, word_type by,
                                                 word_type bz, word_type sc);
      req_payload_type item;
      item = '{func, ax, ay, az, bx, by, bz, sc};
      return item;
   endfunction

   // Extremes, each operation at least once, and the threshold and zero-divisor cases.
   task automatic test_directed();
      word_type one;
      one = word_type'(ONE_Q);
      send_item(make_item(OP_ADD, 32'sh7fffffff, 32'sh80000000, 1, 1, -1, 0, 0));
      send_item(make_item(OP_SUB, 32'sh80000000, 32'sh7fffffff, 5, 1, -1, 5, 0));
      send_item(make_item(OP_MUL, 32'sh7fffffff, -3, 3, 32'sh7fffffff, 1, -1, 0));
      send_item(make_item(OP_SCALE, one, -one, 32'sh80000000, 0, 0, 0, 32'sh80000000));
      send_item(make_item(OP_DIV, 7, -7, 0, 0, 0, 0, 0));
      send_item(make_item(OP_DIV, 32'sh7fffffff, -one, 3, 0, 0, 0, 1));
      send_item(make_item(OP_SDIV, one, 2, 3, 0, 0, 0, word_type'(EPS_Q)));
      send_item(make_item(OP_SDIV, one, 2, 3, 0, 0, 0, word_type'(EPS_Q + 1)));
      send_item(make_item(OP_NEG, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0, 0));
      send_item(make_item(OP_DOT, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0));
      send_item(make_item(OP_CROSS, one, 0, 0, 0, one, 0, 0));
      send_item(make_item(OP_LEN, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0));
      send_item(make_item(OP_LENSQ, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0));
      send_item(make_item(OP_NORM, 6, 0, 0, 0, 0, 0, 0));
      send_item(make_item(OP_NORM, 7, 0, 0, 0, 0, 0, 0));
      send_item(make_item(OP_NORM, 3 * one, 4 * one, 0, 0, 0, 0, 0));
      send_item(make_item(OP_NEARZERO, 0, 0, 0, 5, 5, 5, 5));
      send_item(make_item(OP_NEARZERO, 0, 0, 1, 0, 0, 0, 0));
      send_item(make_item(OP_REFLECT, one, -one, 0, 0, one, 0, 0));
      // Refraction with the cosine clamped to one and with a grazing ray.
      send_item(make_item(OP_REFRACT, 0, -2 * one, 0, 0, one, 0, one));
      send_item(make_item(OP_REFRACT, one, 0, 0, 0, one, 0, one + one / 2));
      send_item(make_item(OP_SPARE, 0, 0, 0, 1, 2, 3, 4));
      send_item(make_item(OP_SPARE, -1, 2, 3, 1, 2, 3, 4));
   endtask

   // Random items on random codes; three in four spare-code items are sent as refract items instead.
   task automatic test_random(int count);
      req_payload_type item;
      for (int n = 0; n < count; n++) begin
         item = random_item(4'($urandom_range(0, 15)));
         if (item.func == OP_SPARE && $urandom_range(0, 3) != 0) item.func = OP_REFRACT;
         send_item(item);
      end
   endtask

   // Receiver: random stalls, compare each result with the oldest prediction.
   initial begin
      rsp_payload_type want;
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         result_count++;
         if (expected_results.size() == 0) begin
            unexpected_count++;
            mismatch_count++;
            if (mismatch_count <= 10) $display("Result with nothing expected: %p", rsp_ch.data);
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch at result %0d: expected %p, got %p",
                           result_count, want, rsp_ch.data);
            end
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(830);
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d items over all %0d operation codes; %0d results checked.",
               item_count, 16, result_count);
      $display("Refract items: %0d, unused-code items: %0d, results with nothing expected: %0d.",
               op_counts[OP_REFRACT], op_counts[OP_SPARE], unexpected_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d still expected", mismatch_count,
                  expected_results.size());
         $display("FAIL");
      end
      $finish;
   end
endmodule

// File: vector3_geometry_unit_core.f
design/vgu_pkg.sv
design/vgu_req_if.sv
design/vgu_rsp_if.sv
design/vector3_geometry_unit_core.sv
test/vgu_testbench.sv
